>>> rtl/calculator_token_scanner_unit_assert.svh
// ----------------------------------------------------------------------------
// Calculator token scanner assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CALCULATOR_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define CALCULATOR_TOKEN_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CTS_ASSERT_IMP(lbl, ante, cons, msg)
`define CTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/ctscan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calculator token scanner package
// Token kinds, scan modes, character classes and keyword matching.
// ----------------------------------------------------------------------------
package ctscan_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int SERIAL_BITS     = 32;
    localparam int KIND_BITS       = 4;
    localparam int WORD_BYTES      = 6;
    // power of two, at least 2
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_IDENT  = 2'd2
    } mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PLUS    = 4'd0,
        KIND_MINUS   = 4'd1,
        KIND_TIMES   = 4'd2,
        KIND_DIVIDE  = 4'd3,
        KIND_LPAREN  = 4'd4,
        KIND_RPAREN  = 4'd5,
        KIND_SEMI    = 4'd6,
        KIND_INTEGER = 4'd7,
        KIND_IDENT   = 4'd8,
        KIND_IF      = 4'd9,
        KIND_RETURN  = 4'd10,
        KIND_EOF     = 4'd11,
        KIND_UNRECOG = 4'd12
    } kind_t;

    typedef struct packed {
        logic first;
        logic second;
    } ctscan_emit_t;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_SEMI    = 8'h3B;

    // keyword text, first character in the lowest byte
    localparam logic [8*WORD_BYTES-1:0] KW_IF     = 48'h0000_0000_6669;
    localparam logic [8*WORD_BYTES-1:0] KW_RETURN = 48'h6E72_7574_6572;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_lower(c) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH)
            || (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SEMI);
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_TIMES;
            CH_SLASH:  k = KIND_DIVIDE;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_UNRECOG;
        endcase
        return k;
    endfunction

    function automatic kind_t word_kind(input logic [8*WORD_BYTES-1:0] text,
                                        input logic [2:0] len);
        kind_t k;
        priority if (len == 3'd2 && text == KW_IF)
            k = KIND_IF;
        else if (len == 3'd6 && text == KW_RETURN)
            k = KIND_RETURN;
        else
            k = KIND_IDENT;
        return k;
    endfunction

endpackage

>>> rtl/ctscan_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calculator token scanner lexer
// Scan state, position counters and token formation, one character a cycle on accept.
// ----------------------------------------------------------------------------
`include "calculator_token_scanner_unit_assert.svh"

module ctscan_lexer
    import ctscan_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    localparam int TOK_W      = KIND_BITS + 1 + LINE_BITS + COLUMN_BITS + SERIAL_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         char_code,
    input  logic               end_mark,
    output ctscan_emit_t       emit,
    output logic [TOK_W-1:0]   tok0,
    output logic [TOK_W-1:0]   tok1
);

    localparam int WBUF_W = 8 * WORD_BYTES;

    mode_t                   mode_reg, mode_next;
    logic [WBUF_W-1:0]       wbuf_reg, wbuf_next;
    logic [2:0]              wlen_reg, wlen_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic [COLUMN_BITS-1:0]  col_reg, col_next;
    logic [SERIAL_BITS-1:0]  count_reg, count_next;

    logic                    cont;
    logic                    close;
    logic                    emit_b;
    kind_t                   kind_a;
    kind_t                   kind_b;
    logic [COLUMN_BITS-1:0]  col_adv;
    logic [LINE_BITS-1:0]    line_adv;
    logic [SERIAL_BITS-1:0]  serial_b;
    logic [TOK_W-1:0]        tok_a;
    logic [TOK_W-1:0]        tok_b;

    assign col_adv  = (col_reg == '1) ? col_reg : col_reg + COLUMN_BITS'(1);
    assign line_adv = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);

    always_comb
    begin
        mode_next = mode_reg;
        wbuf_next = wbuf_reg;
        wlen_next = wlen_reg;
        line_next = line_reg;
        col_next  = col_reg;
        cont      = 1'b0;
        close     = 1'b0;
        emit_b    = 1'b0;
        kind_a    = KIND_INTEGER;
        kind_b    = KIND_EOF;

        unique case (mode_reg)
            MODE_NUMBER:
            begin
                kind_a = KIND_INTEGER;
                if (!end_mark && is_digit(char_code))
                    cont = 1'b1;
                else
                    close = 1'b1;
            end
            MODE_IDENT:
            begin
                kind_a = word_kind(wbuf_reg, wlen_reg);
                if (!end_mark && is_alnum(char_code))
                    cont = 1'b1;
                else
                    close = 1'b1;
            end
            default:
            begin
                kind_a = KIND_INTEGER;
            end
        endcase

        if (cont)
        begin
            col_next = col_adv;
            if (mode_reg == MODE_IDENT)
            begin
                for (int i = 0; i < WORD_BYTES; i++)
                begin
                    if (wlen_reg == 3'(i))
                        wbuf_next[8*i +: 8] = char_code;
                end
                if (wlen_reg != 3'd7)
                    wlen_next = wlen_reg + 3'd1;
            end
        end
        else
        begin
            mode_next = MODE_IDLE;
            priority if (end_mark)
            begin
                col_next = col_adv;
                emit_b   = 1'b1;
                kind_b   = KIND_EOF;
            end
            else if (char_code == CH_NEWLINE)
            begin
                col_next  = COLUMN_BITS'(1);
                line_next = line_adv;
            end
            else
            begin
                col_next = col_adv;
                priority if (is_blank(char_code))
                begin
                    emit_b = 1'b0;
                end
                else if (is_punct(char_code))
                begin
                    emit_b = 1'b1;
                    kind_b = punct_kind(char_code);
                end
                else if (is_digit(char_code))
                begin
                    mode_next = MODE_NUMBER;
                end
                else if (is_lower(char_code))
                begin
                    mode_next = MODE_IDENT;
                    wbuf_next = {{(WBUF_W-8){1'b0}}, char_code};
                    wlen_next = 3'd1;
                end
                else
                begin
                    emit_b = 1'b1;
                    kind_b = KIND_UNRECOG;
                end
            end
        end

        count_next = count_reg + SERIAL_BITS'(close) + SERIAL_BITS'(emit_b);
    end

    assign serial_b = count_reg + SERIAL_BITS'(close);

    // pack: serial, column, line, last, kind (kind lowest)
    assign tok_a = {count_reg, col_reg, line_reg, !emit_b, kind_a};
    assign tok_b = {serial_b, col_next, line_reg, 1'b1, kind_b};

    assign tok0         = close ? tok_a : tok_b;
    assign tok1         = tok_b;
    assign emit.first   = accept && (close || emit_b);
    assign emit.second  = accept && close && emit_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            wbuf_reg  <= '0;
            wlen_reg  <= '0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            wbuf_reg  <= wbuf_next;
            wlen_reg  <= wlen_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            count_reg <= count_next;
        end
    end

    `CTS_ASSERT_IMP(a_ident_has_text, mode_reg == MODE_IDENT, wlen_reg != 3'd0, "identifier without text")
    `CTS_ASSERT_NEXT(a_line_monotonic, accept, line_reg >= $past(line_reg), "line count went back")
    `CTS_ASSERT_NEXT(a_newline_column, accept && !end_mark && char_code == CH_NEWLINE, col_reg == COLUMN_BITS'(1), "column not reset by newline")
    `CTS_ASSERT_IMP(a_continue_silent, accept && cont, !emit.first, "token emitted inside a word")

endmodule

>>> rtl/ctscan_token_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calculator token scanner output queue
// Small token buffer taking up to two tokens a cycle, giving one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
`include "calculator_token_scanner_unit_assert.svh"

module ctscan_token_queue
    import ctscan_pkg::*;
#(
    parameter int TOK_W = 73,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctscan_emit_t      push,
    input  logic [TOK_W-1:0]  tok0,
    input  logic [TOK_W-1:0]  tok1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TOK_W-1:0]  out_tok
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [TOK_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [1:0]       n_push;

    assign n_push      = 2'(push.first) + 2'(push.second);
    assign pop         = out_valid && out_ready;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.first)
            mem_reg[wr_ptr_reg] <= tok0;
        if (push.second)
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CTS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count over depth")
    `CTS_ASSERT_IMP(a_second_after_first, push.second, push.first, "second token without first")
    `CTS_ASSERT_IMP(a_push_has_room, push.first, room, "token pushed without room")
    `CTS_ASSERT_NEXT(a_ptr_distance, 1'b1, PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg), "pointers disagree with count")

endmodule

>>> rtl/calculator_token_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calculator token scanner
// Character stream in, token stream out for a small calculator language.
// ----------------------------------------------------------------------------
// Input stream: one byte per transaction on s_tdata, s_tuser high marks end
// of input (byte ignored). Output stream: one token per transaction, kind on
// m_tuser, position and serial number on m_tdata, m_tlast on the last token
// that one input character produced.
// Each accepted character is scanned in the cycle it is taken; its tokens
// (none, one or two) enter a four-entry queue, which registers them before
// they reach the output.
// Throughput: one character per cycle while s_tready is high, and one token
// per cycle while m_tready is high. s_tready stays high while the queue has
// room for two tokens, since a character that ends a word can push two.
// When the receiver stalls, tokens collect in the queue and s_tready drops
// once fewer than two entries are free.
// Reset: scanner idle, line 1, column 0, serial 0, queue empty.
// ----------------------------------------------------------------------------
module calculator_token_scanner_unit
    import ctscan_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    localparam int DATA_BITS  = LINE_BITS + COLUMN_BITS + SERIAL_BITS,
    localparam int DATA_W     = ((DATA_BITS + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // char_code
    input  logic                 s_tuser,   // end_mark
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // line_number, column_number, serial_number
    output logic [KIND_BITS-1:0] m_tuser,   // token_kind
    output logic                 m_tlast
);

    localparam int TOK_W = KIND_BITS + 1 + DATA_BITS;

    ctscan_emit_t     emit;
    logic             accept;
    logic             room;
    logic [TOK_W-1:0] tok0;
    logic [TOK_W-1:0] tok1;
    logic [TOK_W-1:0] out_tok;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ctscan_lexer #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_tdata),
        .end_mark  (s_tuser),
        .emit      (emit),
        .tok0      (tok0),
        .tok1      (tok1)
    );

    ctscan_token_queue #(
        .TOK_W (TOK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .tok0      (tok0),
        .tok1      (tok1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tuser = out_tok[KIND_BITS-1:0];
    assign m_tlast = out_tok[KIND_BITS];
    assign m_tdata = DATA_W'(out_tok[TOK_W-1:KIND_BITS+1]);

endmodule
